// ===== rtl/shmq_pkg.sv =====
// ----------------------------------------------------------------------------
// shmq_pkg
// shared types, codes and decode helpers for the sensor history mean query
// ----------------------------------------------------------------------------
package shmq_pkg;

  // query codes
  localparam logic [7:0] CODE_LAST_A = 8'hA0;
  localparam logic [7:0] CODE_LAST_B = 8'hA1;
  localparam logic [7:0] CODE_LAST_C = 8'hA2;
  localparam logic [7:0] CODE_MEAN_A = 8'hA3;
  localparam logic [7:0] CODE_MEAN_B = 8'hA4;
  localparam logic [7:0] CODE_MEAN_C = 8'hA5;

  // result status
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
  localparam logic [1:0] STATUS_EMPTY   = 2'd2;

  // command field values
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int SUM_W   = 32;
  localparam int SMALL_W = 16;
  localparam int DIV_CW  = $clog2(SUM_W);

  typedef struct packed {
    logic        command;
    logic [7:0]  sample_a;
    logic [7:0]  sample_b;
    logic [31:0] sample_c;
    logic [7:0]  request_code;
  } req_t;

  typedef struct packed {
    logic [7:0]  echo_code;
    logic [31:0] answer;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [1:0] {
    RING_A,
    RING_B,
    RING_C
  } ring_sel_t;

  typedef enum logic [1:0] {
    KIND_LAST,
    KIND_MEAN,
    KIND_BAD
  } code_kind_t;

  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_QUOT,
    SRC_ZERO
  } res_src_t;

  // controller to datapath
  typedef struct packed {
    logic       store;
    logic       capture;
    logic       walk_clear;
    logic       rd_en;
    logic       rd_newest;
    logic       acc_add;
    logic       div_step;
    logic       res_load;
    res_src_t   res_src;
    logic [1:0] res_status;
  } shmq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_nonzero;
    logic walk_last;
    logic count_zero;
    logic div_last;
    logic rsp_free;
  } shmq_stat_t;

  function automatic code_kind_t code_kind(input logic [7:0] code);
    code_kind_t k;
    case (code)
      CODE_LAST_A, CODE_LAST_B, CODE_LAST_C: k = KIND_LAST;
      CODE_MEAN_A, CODE_MEAN_B, CODE_MEAN_C: k = KIND_MEAN;
      default:                               k = KIND_BAD;
    endcase
    return k;
  endfunction

  function automatic ring_sel_t code_ring(input logic [7:0] code);
    ring_sel_t r;
    case (code)
      CODE_LAST_A, CODE_MEAN_A: r = RING_A;
      CODE_LAST_B, CODE_MEAN_B: r = RING_B;
      default:                  r = RING_C;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/sensor_history_mean_query_top.sv =====
// store beat: taken while idle, no result; the next beat can follow at once
// newest-sample query: ring read in S_LAST_RD, result loaded in S_FIN once the result register is free
// mean query: each ring entry is read (S_MEAN_RD) and checked (S_MEAN_CHK), then the bit-serial
//   divider runs and S_FIN loads the result; one query in flight at a time
// reset: synchronous, clears the write pointer, all ring valid bits (rings read
//   as zero) and the result valid flag; no clearing pass is needed
// ----------------------------------------------------------------------------
// sensor_history_mean_query_top
// three sample rings with a shared write pointer, answering newest-sample and
// leading-run mean queries
// ----------------------------------------------------------------------------
module sensor_history_mean_query_top #(
  parameter int RING_DEPTH = 11
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  shmq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output shmq_pkg::rsp_t rsp
);
  import shmq_pkg::*;

  // command and status between sequencer and datapath
  shmq_cmd_t  cmd;
  shmq_stat_t stat;

  // sequencer: accepts a beat only when idle, steps the walk and divide
  shmq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .command      (req.command),
    .request_code (req.request_code),
    .stat         (stat),
    .cmd          (cmd)
  );

  // datapath: rings, accumulator, divider and the result register that
  // decouples the response side
  shmq_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // a new result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten");

  // rings are written only by an accepted store beat
  a_store_beat: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (req_valid && req_ready && req.command == CMD_STORE))
    else $error("ring write without store beat");

  // the divider never runs with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !stat.count_zero)
    else $error("divide by zero count");

  // no new beat is taken while a query is still being worked on
  a_one_query: assert property (@(posedge clk) disable iff (rst)
    (cmd.capture && !cmd.res_load) |=> !req_ready)
    else $error("request accepted during query");

endmodule

// ===== rtl/shmq_ctrl.sv =====
// ----------------------------------------------------------------------------
// shmq_ctrl
// sequencer for store, newest-sample and mean queries
// ----------------------------------------------------------------------------
module shmq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic                command,
  input  logic [7:0]          request_code,
  input  shmq_pkg::shmq_stat_t stat,
  output shmq_pkg::shmq_cmd_t  cmd
);
  import shmq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_LAST_RD   = 7'b0000010,
    S_LAST_WAIT = 7'b0000100,
    S_MEAN_RD   = 7'b0001000,
    S_MEAN_CHK  = 7'b0010000,
    S_DIV       = 7'b0100000,
    S_FIN       = 7'b1000000
  } state_t;

  state_t     state, state_next;
  res_src_t   fin_src, fin_src_next;
  logic [1:0] fin_status, fin_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fin_src    <= SRC_ZERO;
      fin_status <= STATUS_OK;
    end else begin
      state      <= state_next;
      fin_src    <= fin_src_next;
      fin_status <= fin_status_next;
    end
  end

  always_comb begin
    state_next      = state;
    fin_src_next    = fin_src;
    fin_status_next = fin_status;
    cmd             = '0;
    cmd.res_src     = fin_src;
    cmd.res_status  = fin_status;
    req_ready       = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (command == CMD_STORE) begin
            cmd.store = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            case (code_kind(request_code))
              KIND_LAST: state_next = S_LAST_RD;
              KIND_MEAN: begin
                cmd.walk_clear = 1'b1;
                state_next     = S_MEAN_RD;
              end
              default: begin
                fin_src_next    = SRC_ZERO;
                fin_status_next = STATUS_UNKNOWN;
                state_next      = S_FIN;
              end
            endcase
          end
        end
      end
      S_LAST_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_newest = 1'b1;
        state_next    = S_LAST_WAIT;
      end
      S_LAST_WAIT: begin
        fin_src_next    = SRC_DATA;
        fin_status_next = STATUS_OK;
        state_next      = S_FIN;
      end
      S_MEAN_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_MEAN_CHK;
      end
      S_MEAN_CHK: begin
        if (stat.rd_nonzero) begin
          cmd.acc_add = 1'b1;
          state_next  = stat.walk_last ? S_DIV : S_MEAN_RD;
        end else if (stat.count_zero) begin
          fin_src_next    = SRC_ZERO;
          fin_status_next = STATUS_EMPTY;
          state_next      = S_FIN;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          fin_src_next    = SRC_QUOT;
          fin_status_next = STATUS_OK;
          state_next      = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.rsp_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/shmq_dp.sv =====
// ----------------------------------------------------------------------------
// shmq_dp
// sample rings, walk accumulator, serial divider and result register
// ----------------------------------------------------------------------------
module shmq_dp #(
  parameter int RING_DEPTH = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  shmq_pkg::req_t       req,
  input  shmq_pkg::shmq_cmd_t  cmd,
  output shmq_pkg::shmq_stat_t stat,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output shmq_pkg::rsp_t       rsp
);
  import shmq_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  logic [7:0]  mem_a [RING_DEPTH];
  logic [7:0]  mem_b [RING_DEPTH];
  logic [31:0] mem_c [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld;

  logic [AW-1:0] wp, newest, idx, rd_addr;
  logic [7:0]    rd_a, rd_b;
  logic [31:0]   rd_c;
  logic          rd_vld;
  logic [7:0]    code_q;
  ring_sel_t     sel;
  logic [SUM_W-1:0]  sum;
  logic [CW-1:0]     count, rem;
  logic [DIV_CW-1:0] dcnt;
  logic [SUM_W-1:0]  sel_data;
  logic [CW:0]       trial, diff;
  logic              ge;
  logic [SUM_W-1:0]  answer_next;

  assign newest  = (wp == '0) ? LAST_IDX : wp - AW'(1);
  assign rd_addr = cmd.rd_newest ? newest : idx;

  // rings, read through a registered port; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem_a[wp] <= req.sample_a;
      mem_b[wp] <= req.sample_b;
      mem_c[wp] <= req.sample_c;
    end
    if (cmd.rd_en) begin
      rd_a   <= mem_a[rd_addr];
      rd_b   <= mem_b[rd_addr];
      rd_c   <= mem_c[rd_addr];
      rd_vld <= vld[rd_addr];
    end
  end

  always_comb begin
    case (sel)
      RING_A:  sel_data = {24'b0, rd_a};
      RING_B:  sel_data = {24'b0, rd_b};
      RING_C:  sel_data = rd_c;
      default: sel_data = '0;
    endcase
    sel_data = rd_vld ? sel_data : '0;
  end

  // one restoring divide step
  assign trial = {rem, sum[SUM_W-1]};
  assign ge    = trial >= {1'b0, count};
  assign diff  = trial - {1'b0, count};

  always_comb begin
    case (cmd.res_src)
      SRC_DATA: answer_next = sel_data;
      SRC_QUOT: answer_next = sum;
      default:  answer_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      wp        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.store) begin
        vld[wp] <= 1'b1;
        wp      <= (wp == LAST_IDX) ? '0 : wp + AW'(1);
      end
      if (cmd.res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      code_q <= req.request_code;
      sel    <= code_ring(req.request_code);
    end
    if (cmd.walk_clear) begin
      idx   <= '0;
      sum   <= '0;
      count <= '0;
      rem   <= '0;
      dcnt  <= '0;
    end else if (cmd.acc_add) begin
      idx   <= idx + AW'(1);
      count <= count + CW'(1);
      if (sel == RING_C) begin
        sum <= sum + sel_data;
      end else begin
        sum <= {{(SUM_W-SMALL_W){1'b0}}, sum[SMALL_W-1:0] + sel_data[SMALL_W-1:0]};
      end
    end else if (cmd.div_step) begin
      rem  <= ge ? diff[CW-1:0] : trial[CW-1:0];
      sum  <= {sum[SUM_W-2:0], ge};
      dcnt <= dcnt + DIV_CW'(1);
    end
    if (cmd.res_load) begin
      rsp.echo_code <= code_q;
      rsp.answer    <= answer_next;
      rsp.status    <= cmd.res_status;
    end
  end

  assign stat.rd_nonzero = sel_data != '0;
  assign stat.walk_last  = idx == LAST_IDX;
  assign stat.count_zero = count == '0;
  assign stat.div_last   = dcnt == '1;
  assign stat.rsp_free   = !rsp_valid || rsp_ready;

endmodule
